>>> rtl/gle_pkg.sv
package gle_pkg;

   localparam int BYTE_W = 8;

   // configuration register map
   localparam int REG_MIN_CODE_SIZE = 0;

   // root symbol width limits and reset value
   localparam logic [3:0] MIN_CODE_LO    = 4'd2;
   localparam logic [3:0] MIN_CODE_HI    = 4'd8;
   localparam logic [3:0] MIN_CODE_RESET = 4'd8;

   typedef struct packed {
      logic [7:0] pixel_index;
      logic       last_pixel;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

   function automatic logic [3:0] clamp_min(input logic [3:0] m);
      logic [3:0] r;
      r = m;
      if (m < MIN_CODE_LO) r = MIN_CODE_LO;
      if (m > MIN_CODE_HI) r = MIN_CODE_HI;
      return r;
   endfunction

endpackage

>>> rtl/gle_ram.sv
module gle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/gif_lzw_encoder_top.sv
// GIF-style LZW encoder. One palette index per req transaction, codes packed
// lsb first into bytes, one byte per rsp transaction (run_last marks the last
// byte of an input transaction, stream_end the final padded byte of an image).
// The dictionary is a child/sibling tree in two RAMs: a first-child table
// indexed by prefix code and a code table holding (prefix, symbol, older
// sibling). Entries are validated against the live code range and the stored
// prefix, so no clearing pass is needed after reset or a dictionary restart.
// Steps: the first pixel of an image is taken in the accept step alone unless
// it is also the last one. Any other pixel goes through the accept, a head read
// and a lookup walk that visits one candidate at a time (up to 2^min_code_size
// candidates for a prefix with a full set of children). A hit ends there. A miss
// puts its codes into the bit packer (miss, clear, flush steps), then sends
// one byte per cycle while rsp_ready is high and then returns to idle; no new
// pixel is taken before that. A last pixel always goes through flush and drain.
// The throughput is set by the serial walk through the code RAM.
// min_code_size is to be written over the csr port only while idle; the block
// does not enforce this. It is latched at the first pixel of each image.
module gif_lzw_encoder_top #(
   parameter int MAX_CODE_BITS = 12,
   parameter int DICT_ENTRIES  = 4096
) (
   input  logic              clock,
   input  logic              reset,
   // pixel channel
   input  logic              req_valid,
   output logic              req_ready,
   input  gle_pkg::req_type  req_data,
   // byte channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gle_pkg::rsp_type  rsp_data,
   // configuration
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int CW    = MAX_CODE_BITS;          // code width
   localparam int NCW   = MAX_CODE_BITS + 1;      // next code width
   localparam int AW    = $clog2(DICT_ENTRIES);
   localparam int ACC_W = 8 + 3 * MAX_CODE_BITS;  // leftover bits plus three codes
   localparam int CNT_W = $clog2(ACC_W + 1);
   localparam int ENT_W = 2 * CW + 8;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HEAD  = 3'd1;
   localparam logic [2:0] ST_CHAIN = 3'd2;
   localparam logic [2:0] ST_MISS  = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;
   localparam logic [2:0] ST_DRAIN = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [3:0]       min_code_ff;
   logic [3:0]       active_ff, active_in;
   logic             have_prefix_ff, have_prefix_in;
   logic [CW-1:0]    prefix_ff, prefix_in;
   logic [NCW-1:0]   next_code_ff, next_code_in;
   logic [3:0]       width_ff, width_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       pix_ff, pix_in;
   logic             last_ff, last_in;
   logic             flush_ff, flush_in;
   logic [CW-1:0]    cand_ff, cand_in;
   logic [CW-1:0]    head_ff, head_in;
   logic             head_ok_ff, head_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   gle_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // shared bit packer port
   logic             put_en;
   logic [CW-1:0]    put_code;

   // ram ports
   logic             ram_we;
   logic [CW-1:0]    fc_rdata;
   logic [ENT_W-1:0] ent_rdata;
   logic [CW-1:0]    ent_prefix;
   logic [7:0]       ent_symbol;
   logic [CW-1:0]    ent_sibling;

   logic             req_fire;
   logic             csr_write;
   logic [3:0]       min_sel;
   logic [8:0]       pix_mask;
   logic [8:0]       clear_code;
   logic [NCW-1:0]   nc_inc;
   logic [NCW-1:0]   width_top;
   logic             slot_free;
   logic [CNT_W-1:0] rem_cnt;
   logic             byte_rdy;
   logic             more_bytes;

   function automatic logic live_code(input logic [CW-1:0] c,
                                      input logic [NCW-1:0] lo,
                                      input logic [NCW-1:0] hi);
      logic [NCW-1:0] cx;
      cx = NCW'(c);
      return (cx >= lo) && (cx < hi) && (cx < NCW'(DICT_ENTRIES));
   endfunction

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // csr port, single register, writes land in the access cycle
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite
                      && (paddr[2] == 1'(gle_pkg::REG_MIN_CODE_SIZE));
   assign prdata    = {28'd0, min_code_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_code_ff <= gle_pkg::MIN_CODE_RESET;
      end else if (csr_write) begin
         min_code_ff <= pwdata[3:0];
      end
   end

   // root width of the incoming pixel: fresh from the register on a first pixel
   assign min_sel    = have_prefix_ff ? active_ff : gle_pkg::clamp_min(min_code_ff);
   assign pix_mask   = (9'd1 << min_sel) - 9'd1;
   assign clear_code = 9'd1 << active_ff;
   assign nc_inc     = next_code_ff + NCW'(1);
   assign width_top  = NCW'(1) << width_ff;

   assign ent_prefix  = ent_rdata[ENT_W-1 -: CW];
   assign ent_symbol  = ent_rdata[CW +: 8];
   assign ent_sibling = ent_rdata[CW-1:0];

   assign ram_we = (state_ff == ST_MISS) && (next_code_ff < NCW'(DICT_ENTRIES));

   // first child of each prefix (most recent insert)
   gle_ram #(
      .WIDTH (CW),
      .DEPTH (DICT_ENTRIES)
   ) u_first_child (
      .clock (clock),
      .we    (ram_we),
      .waddr (prefix_ff[AW-1:0]),
      .wdata (next_code_ff[CW-1:0]),
      .raddr (prefix_ff[AW-1:0]),
      .rdata (fc_rdata)
   );

   // code table: prefix, symbol, next older sibling
   gle_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DICT_ENTRIES)
   ) u_code_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (next_code_ff[AW-1:0]),
      .wdata ({prefix_ff, pix_ff, (head_ok_ff ? head_ff : CW'(0))}),
      .raddr (cand_in[AW-1:0]),
      .rdata (ent_rdata)
   );

   // byte drain bookkeeping
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign byte_rdy   = (cnt_ff >= CNT_W'(8)) || (flush_ff && (cnt_ff != '0));
   assign rem_cnt    = (cnt_ff > CNT_W'(8)) ? cnt_ff - CNT_W'(8) : '0;
   assign more_bytes = (rem_cnt >= CNT_W'(8)) || (flush_ff && (rem_cnt != '0));

   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      have_prefix_in = have_prefix_ff;
      prefix_in      = prefix_ff;
      next_code_in   = next_code_ff;
      width_in       = width_ff;
      pix_in         = pix_ff;
      last_in        = last_ff;
      flush_in       = flush_ff;
      cand_in        = cand_ff;
      head_in        = head_ff;
      head_ok_in     = head_ok_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      put_en         = 1'b0;
      put_code       = prefix_ff;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pix_in   = req_data.pixel_index & pix_mask[7:0];
               last_in  = req_data.last_pixel;
               flush_in = 1'b0;
               if (!have_prefix_ff) begin
                  // first pixel of an image: restart everything
                  active_in      = min_sel;
                  width_in       = min_sel + 4'd1;
                  next_code_in   = (NCW'(1) << min_sel) + NCW'(2);
                  acc_in         = '0;
                  cnt_in         = '0;
                  prefix_in      = CW'(req_data.pixel_index & pix_mask[7:0]);
                  have_prefix_in = 1'b1;
                  state_in       = req_data.last_pixel ? ST_FLUSH : ST_IDLE;
               end else begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            head_in    = fc_rdata;
            head_ok_in = live_code(fc_rdata, NCW'(clear_code) + NCW'(2), next_code_ff);
            if (head_ok_in) begin
               cand_in  = fc_rdata;
               state_in = ST_CHAIN;
            end else begin
               state_in = ST_MISS;
            end
         end
         ST_CHAIN: begin
            if (ent_prefix != prefix_ff) begin
               // stale head from an earlier dictionary
               head_ok_in = 1'b0;
               state_in   = ST_MISS;
            end else if (ent_symbol == pix_ff) begin
               prefix_in = cand_ff;
               state_in  = last_ff ? ST_FLUSH : ST_IDLE;
            end else if (live_code(ent_sibling, NCW'(clear_code) + NCW'(2),
                                   next_code_ff)) begin
               cand_in = ent_sibling;
            end else begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            put_en    = 1'b1;
            put_code  = prefix_ff;
            prefix_in = CW'(pix_ff);
            next_code_in = nc_inc;
            state_in  = last_ff ? ST_FLUSH : ST_DRAIN;
            if (nc_inc >= width_top) begin
               if (width_ff >= 4'(MAX_CODE_BITS)) begin
                  state_in = ST_CLEAR;
               end else if (nc_inc >= width_top + NCW'(1)) begin
                  width_in = width_ff + 4'd1;
               end
            end
         end
         ST_CLEAR: begin
            put_en       = 1'b1;
            put_code     = CW'(clear_code);
            width_in     = active_ff + 4'd1;
            next_code_in = NCW'(clear_code) + NCW'(2);
            state_in     = last_ff ? ST_FLUSH : ST_DRAIN;
         end
         ST_FLUSH: begin
            put_en   = 1'b1;
            put_code = prefix_ff;
            flush_in = 1'b1;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!byte_rdy) begin
               if (flush_ff) begin
                  have_prefix_in = 1'b0;
                  acc_in         = '0;
                  flush_in       = 1'b0;
               end
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_byte   = acc_ff[7:0];
               rsp_data_in.run_last   = !more_bytes;
               rsp_data_in.stream_end = flush_ff && !more_bytes;
               acc_in = acc_ff >> 8;
               cnt_in = rem_cnt;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // shared packer: or the code in above the pending bits
      if (put_en) begin
         acc_in = acc_ff | (ACC_W'(put_code) << cnt_ff);
         cnt_in = cnt_ff + CNT_W'(width_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_ff      <= gle_pkg::MIN_CODE_RESET;
         have_prefix_ff <= 1'b0;
         prefix_ff      <= '0;
         next_code_ff   <= (NCW'(1) << gle_pkg::MIN_CODE_RESET) + NCW'(2);
         width_ff       <= gle_pkg::MIN_CODE_RESET + 4'd1;
         acc_ff         <= '0;
         cnt_ff         <= '0;
         flush_ff       <= 1'b0;
         last_ff        <= 1'b0;
         head_ok_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_ff      <= active_in;
         have_prefix_ff <= have_prefix_in;
         prefix_ff      <= prefix_in;
         next_code_ff   <= next_code_in;
         width_ff       <= width_in;
         acc_ff         <= acc_in;
         cnt_ff         <= cnt_in;
         flush_ff       <= flush_in;
         last_ff        <= last_in;
         head_ok_ff     <= head_ok_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      cand_ff     <= cand_in;
      head_ff     <= head_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> tb/gif_lzw_encoder_checker.sv
`timescale 1ns / 100ps

module gif_lzw_encoder_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  gle_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  gle_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   input  logic             pready,
   output int               mismatches,
   output int               pending,
   output int               bytes_seen
);

   localparam int CODE_BITS_MAX = 12;
   localparam int CODE_SPACE    = 4096;

   // shadow encoder state
   logic [11:0] tree_prefix [CODE_SPACE];
   logic [7:0]  tree_symbol [CODE_SPACE];
   logic [3:0]  min_size_reg;
   int          root_bits;
   int          prefix;
   bit          in_image;
   int          free_code;
   int          width;
   logic [31:0] bit_buf;
   int          bit_fill;

   gle_pkg::rsp_type item_bytes[$];
   gle_pkg::rsp_type byte_queue[$];

   function automatic int clamped_root(input logic [3:0] m);
      if (m < gle_pkg::MIN_CODE_LO) return gle_pkg::MIN_CODE_LO;
      if (m > gle_pkg::MIN_CODE_HI) return gle_pkg::MIN_CODE_HI;
      return m;
   endfunction

   task automatic take_byte(input logic [7:0] b);
      gle_pkg::rsp_type r;
      if (item_bytes.size() < 6) begin
         r = '0;
         r.out_byte = b;
         item_bytes.push_back(r);
      end
   endtask

   task automatic pack_code(input int code);
      bit_buf  = bit_buf | (32'(code & 12'hfff) << bit_fill);
      bit_fill = bit_fill + width;
      while (bit_fill >= 8) begin
         take_byte(bit_buf[7:0]);
         bit_buf  = bit_buf >> 8;
         bit_fill = bit_fill - 8;
      end
   endtask

   task automatic restart_codes();
      width     = root_bits + 1;
      free_code = (1 << root_bits) + 2;
   endtask

   task automatic encode_pixel(input gle_pkg::req_type px);
      int  sym;
      int  hit_code;
      bit  hit;
      item_bytes.delete();
      if (!in_image) begin
         root_bits = clamped_root(min_size_reg);
         restart_codes();
         bit_buf  = '0;
         bit_fill = 0;
         prefix   = px.pixel_index & ((1 << root_bits) - 1);
         in_image = 1'b1;
      end else begin
         sym = px.pixel_index & ((1 << root_bits) - 1);
         hit = 1'b0;
         hit_code = 0;
         for (int c = (1 << root_bits) + 2; c < free_code && c < CODE_SPACE; c++) begin
            if (!hit && tree_prefix[c] == prefix && tree_symbol[c] == sym) begin
               hit = 1'b1;
               hit_code = c;
            end
         end
         if (hit) begin
            prefix = hit_code;
         end else begin
            if (free_code < CODE_SPACE) begin
               tree_prefix[free_code] = prefix;
               tree_symbol[free_code] = sym;
            end
            pack_code(prefix);
            free_code++;
            if (free_code >= (1 << width)) begin
               if (width >= CODE_BITS_MAX) begin
                  pack_code(1 << root_bits);
                  restart_codes();
               end else if (free_code >= (1 << width) + 1) begin
                  width++;
               end
            end
            prefix = sym;
         end
      end
      if (px.last_pixel) begin
         pack_code(prefix);
         while (bit_fill > 0) begin
            take_byte(bit_buf[7:0]);
            bit_buf  = bit_buf >> 8;
            bit_fill = (bit_fill > 8) ? bit_fill - 8 : 0;
         end
         if (item_bytes.size() > 0) item_bytes[$].stream_end = 1'b1;
         bit_buf  = '0;
         in_image = 1'b0;
      end
      if (item_bytes.size() > 0) item_bytes[$].run_last = 1'b1;
      foreach (item_bytes[i]) byte_queue.push_back(item_bytes[i]);
   endtask

   initial begin
      mismatches = 0;
      pending    = 0;
      bytes_seen = 0;
   end

   always @(posedge clock) begin
      gle_pkg::rsp_type want;
      if (reset) begin
         min_size_reg = gle_pkg::MIN_CODE_RESET;
         root_bits    = gle_pkg::MIN_CODE_RESET;
         prefix       = 0;
         in_image     = 1'b0;
         restart_codes();
         bit_buf      = '0;
         bit_fill     = 0;
         byte_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready
             && paddr == 3'(gle_pkg::REG_MIN_CODE_SIZE * 4))
            min_size_reg = pwdata[3:0];
         if (req_valid && req_ready)
            encode_pixel(req_data);
         if (rsp_valid && rsp_ready) begin
            bytes_seen++;
            if (byte_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected byte transaction %p", rsp_data);
            end else begin
               want = byte_queue.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.run_last !== want.run_last
                   || rsp_data.stream_end !== want.stream_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"byte mismatch: expected byte %02h run_last %b end %b, ",
                               "got %02h %b %b"},
                              want.out_byte, want.run_last, want.stream_end,
                              rsp_data.out_byte, rsp_data.run_last, rsp_data.stream_end);
               end
            end
         end
      end
      pending = byte_queue.size();
   end

endmodule

>>> tb/gif_lzw_encoder_top_tb.sv
`timescale 1ns / 100ps

module gif_lzw_encoder_top_tb;

   // generous bound: some 300 pixels in short images with random stalls
   localparam int CYCLE_LIMIT = 500_000;
   localparam int DRAIN_WAIT  = 40;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   gle_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   gle_pkg::rsp_type rsp_data;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [2:0]       paddr;
   logic [31:0]      pwdata;
   logic [31:0]      prdata;
   logic             pready;

   int  mismatches;
   int  pending;
   int  bytes_seen;
   int  cycles;
   int  pixels_sent;
   int  images_sent;
   bit  no_stall;   // quiet stretch: neither side idles

   gif_lzw_encoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // watches both channels and the csr port, predicts the byte stream
   gif_lzw_encoder_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .mismatches (mismatches),
      .pending    (pending),
      .bytes_seen (bytes_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still expected", cycles, pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // byte side back-pressure, changed at the falling edge
   always @(negedge clock) begin
      if (reset || no_stall) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 23);
      end
   end

   // one apb write: setup cycle, then access cycle
   task automatic csr_write(input logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = 3'(gle_pkg::REG_MIN_CODE_SIZE * 4);
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // hold a pixel transaction until accepted, then maybe idle (we sit at a negedge)
   task automatic send_pixel(input logic [7:0] pix, input bit last);
      req_data.pixel_index = pix;
      req_data.last_pixel  = last;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      pixels_sent++;
      if (last) images_sent++;
      if (!no_stall && $urandom_range(99) < 23) begin
         req_valid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
   endtask

   // registers change only once the block has gone idle
   task automatic settle_and_config(input logic [31:0] value);
      req_valid = 1'b0;
      while (pending != 0 || !req_ready) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_write(value);
   endtask

   // random image: narrow alphabets give long dictionary strings
   task automatic random_image(input int len);
      int alpha;
      alpha = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
         case (alpha)
            0: send_pixel(8'($urandom_range(1)), i == len - 1);
            1: send_pixel(8'($urandom_range(3)) | 8'($urandom_range(3) << 6), i == len - 1);
            default: send_pixel(8'($urandom), i == len - 1);
         endcase
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      no_stall  = 1'b0;
      pixels_sent = 0;
      images_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset width of 8: extremes of the index, single-pixel image
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hff, 1'b0);
      send_pixel(8'hff, 1'b0);
      send_pixel(8'hff, 1'b0);
      send_pixel(8'h55, 1'b1);
      send_pixel(8'haa, 1'b1);

      // out of range low clamps to 2, upper index bits get masked
      settle_and_config(32'h0);
      send_pixel(8'hff, 1'b0);
      send_pixel(8'h03, 1'b0);
      send_pixel(8'h03, 1'b0);
      send_pixel(8'h03, 1'b0);
      send_pixel(8'h03, 1'b0);
      send_pixel(8'hfc, 1'b1);

      // write mid-image only takes effect on the next image
      settle_and_config(32'h2);
      send_pixel(8'h01, 1'b0);
      send_pixel(8'h02, 1'b0);
      settle_and_config(32'hffff_ffff);   // clamps to 8 at the next image
      send_pixel(8'h01, 1'b0);
      send_pixel(8'h02, 1'b1);
      send_pixel(8'hf0, 1'b0);
      send_pixel(8'h0f, 1'b1);

      // random images over random widths, with a stall-free stretch in the middle
      while (pixels_sent < 300) begin
         no_stall = (pixels_sent > 120 && pixels_sent < 180);
         settle_and_config($urandom_range(1) ? 32'($urandom_range(15)) : 32'($urandom));
         random_image($urandom_range(1) ? $urandom_range(40, 1) : $urandom_range(4, 1));
      end
      no_stall = 1'b0;

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d pixels in %0d images encoded, %0d bytes checked",
               pixels_sent, images_sent, bytes_seen);
      $display("widths clamped and swept, mid-image writes and random back-pressure covered");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d byte mismatches", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/gle_pkg.sv
rtl/gle_ram.sv
rtl/gif_lzw_encoder_top.sv
tb/gif_lzw_encoder_checker.sv
tb/gif_lzw_encoder_top_tb.sv
